// ===== hdl/bnms_pkg.sv =====
// ---------------------------------------------------------------------------
// bnms_pkg: shared types and constants for the box suppression core
// Register addresses, widths, reset values and command/status structs.
// ---------------------------------------------------------------------------
package bnms_pkg;

	localparam int MaxBoxesDef = 64;
	localparam int CoordW      = 16;
	localparam int ScoreW      = 16;
	localparam int ClassW      = 8;
	localparam int BoxW        = 4 * CoordW + ScoreW + ClassW;
	localparam int AreaW       = 2 * CoordW;

	localparam logic [0:0] RegScoreThr   = 1'b0;
	localparam logic [0:0] RegOverlapThr = 1'b1;

	localparam logic [15:0] ScoreThrReset   = 16'd16384;
	localparam logic [15:0] OverlapThrReset = 16'd29491;

	// controller to datapath
	typedef struct packed {
		logic ins_start;   // load new box, start walk at the tail
		logic ins_step;    // shift one entry up / write when place found
		logic out_load;    // read pivot entry
		logic cmp_load;    // read candidate entry
		logic cmp_mark;    // judge candidate, mark if overlapping
		logic emit;        // latch pivot entry for the sweep
		logic res_load;    // load output register from latched pivot
		logic emit_empty;  // load empty-frame result
		logic clear;       // end of frame
	} bnms_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic ins_done;
		logic cand_removed;
		logic pivot_removed;
		logic none_after;  // no live box after the pivot
	} bnms_sts_t;

endpackage

// ===== hdl/bnms_datapath.sv =====
// ---------------------------------------------------------------------------
// bnms_datapath: box store, sorted insertion and overlap test
// Holds the score-ordered box memory, removal marks and the output register.
// ---------------------------------------------------------------------------
module bnms_datapath #(
	parameter int MAX_BOXES = bnms_pkg::MaxBoxesDef,
	parameter int IDX_W     = $clog2(MAX_BOXES),
	parameter int CNT_W     = $clog2(MAX_BOXES + 1)
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  bnms_pkg::bnms_cmd_t         cmd,
	output bnms_pkg::bnms_sts_t         sts,
	input  logic [IDX_W-1:0]            pivot_idx,
	input  logic [IDX_W-1:0]            cand_idx,
	input  logic [CNT_W-1:0]            count,
	input  logic [15:0]                 overlap_thr,
	input  logic [bnms_pkg::BoxW-1:0]   new_box,
	input  logic                        last_out,
	input  logic                        overflow,
	output logic [bnms_pkg::BoxW-1:0]   res_box,
	output logic                        res_none,
	output logic                        res_drop,
	output logic                        res_last
);
	localparam int BW = bnms_pkg::BoxW;
	localparam int CW = bnms_pkg::CoordW;
	localparam int AW = bnms_pkg::AreaW;

	logic [BW-1:0]        mem_q [MAX_BOXES];
	logic [MAX_BOXES-1:0] removed_q;
	logic [BW-1:0]        box_q;        // box being inserted
	logic [CNT_W-1:0]     pos_q;        // free slot during insertion
	logic                 ins_rd_ok_q;  // rd_q holds entry pos_q-1
	logic [BW-1:0]        rd_q;         // memory read register
	logic [BW-1:0]        pivot_q;
	logic [AW-1:0]        inter_s1, area_a_s1, area_b_s1;
	logic                 cmp_v_s1;
	logic [IDX_W-1:0]     cand_s1;

	// field helpers: box = {class, score, bottom, right, top, left}
	function automatic logic [CW-1:0] crd(input logic [BW-1:0] b, input int k);
		crd = b[k*CW +: CW];
	endfunction
	function automatic logic [CW-1:0] span(input logic [CW-1:0] lo, input logic [CW-1:0] hi);
		span = (hi > lo) ? hi - lo : '0;
	endfunction

	logic [CW-1:0] pos_sc_new, pos_sc_rd;
	assign pos_sc_new = box_q[4*CW +: CW];
	assign pos_sc_rd  = rd_q[4*CW +: CW];

	// insertion: pos_q walks down while the entry above scores lower
	logic              shift_up;
	logic [IDX_W-1:0]  pos_idx, pos_m1;
	assign pos_idx  = pos_q[IDX_W-1:0];
	assign pos_m1   = pos_idx - 1'b1;
	assign shift_up = (pos_q != '0) && ins_rd_ok_q && (pos_sc_rd < pos_sc_new);
	assign sts.ins_done = (pos_q == '0) || (ins_rd_ok_q && !(pos_sc_rd < pos_sc_new));

	// memory read address
	logic [IDX_W-1:0] rd_addr;
	always_comb begin
		if (cmd.out_load)
			rd_addr = pivot_idx;
		else if (cmd.cmp_load)
			rd_addr = cand_idx;
		else if (cmd.ins_step && shift_up)
			rd_addr = pos_m1 - 1'b1;
		else
			rd_addr = pos_m1;
	end

	// single write port, registered read held between reads
	always_ff @(posedge clk) begin
		if (cmd.ins_step && shift_up)
			mem_q[pos_idx] <= rd_q;
		else if (cmd.ins_step && sts.ins_done)
			mem_q[pos_idx] <= box_q;
		if (cmd.out_load || cmd.cmp_load || cmd.ins_step)
			rd_q <= mem_q[rd_addr];
	end

	// insertion pointer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q       <= '0;
			ins_rd_ok_q <= 1'b0;
		end else if (cmd.ins_start) begin
			pos_q       <= count;
			ins_rd_ok_q <= 1'b0;
		end else if (cmd.ins_step) begin
			if (shift_up) begin
				pos_q       <= pos_q - 1'b1;
				ins_rd_ok_q <= (pos_q > CNT_W'(1)) && (rd_addr == pos_m1 - 1'b1);
			end else
				ins_rd_ok_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.ins_start)
			box_q <= new_box;
		if (cmd.emit)
			pivot_q <= rd_q;
	end

	// overlap stage 1: intersection and areas, registered
	logic [CW-1:0] il, it, ir, ib;
	always_comb begin
		il = (crd(pivot_q,0) > crd(rd_q,0)) ? crd(pivot_q,0) : crd(rd_q,0);
		it = (crd(pivot_q,1) > crd(rd_q,1)) ? crd(pivot_q,1) : crd(rd_q,1);
		ir = (crd(pivot_q,2) < crd(rd_q,2)) ? crd(pivot_q,2) : crd(rd_q,2);
		ib = (crd(pivot_q,3) < crd(rd_q,3)) ? crd(pivot_q,3) : crd(rd_q,3);
	end
	always_ff @(posedge clk) begin
		inter_s1  <= span(il, ir) * span(it, ib);
		area_a_s1 <= span(crd(pivot_q,0), crd(pivot_q,2)) * span(crd(pivot_q,1), crd(pivot_q,3));
		area_b_s1 <= span(crd(rd_q,0), crd(rd_q,2)) * span(crd(rd_q,1), crd(rd_q,3));
		cand_s1   <= cand_idx;
	end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			cmp_v_s1 <= 1'b0;
		else
			cmp_v_s1 <= cmd.cmp_mark;
	end

	// overlap stage 2: inter * 2^16 > thr * union
	logic [AW:0]    uni;
	logic [AW+16:0] lhs, rhs;
	assign uni = {1'b0, area_a_s1} + {1'b0, area_b_s1} - {1'b0, inter_s1};
	assign lhs = {1'b0, inter_s1, 16'd0};
	assign rhs = (AW+17)'(overlap_thr) * (AW+17)'(uni);

	// removal marks
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			removed_q <= '0;
		else if (cmd.clear)
			removed_q <= '0;
		else if (cmp_v_s1 && (lhs > rhs))
			removed_q[cand_s1] <= 1'b1;
	end
	assign sts.cand_removed  = removed_q[cand_idx];
	assign sts.pivot_removed = removed_q[pivot_idx];

	// live boxes stored after the pivot; none left means this result ends the list
	logic [MAX_BOXES-1:0] live_after;
	always_comb begin
		for (int k = 0; k < MAX_BOXES; k++)
			live_after[k] = !removed_q[k] && (CNT_W'(k) > CNT_W'(pivot_idx))
			                && (CNT_W'(k) < count);
	end
	assign sts.none_after = ~|live_after;

	// output register
	always_ff @(posedge clk) begin
		if (cmd.res_load) begin
			res_box  <= pivot_q;
			res_none <= 1'b0;
			res_drop <= overflow;
			res_last <= last_out;
		end else if (cmd.emit_empty) begin
			res_box  <= '0;
			res_none <= 1'b1;
			res_drop <= overflow;
			res_last <= 1'b1;
		end
	end
endmodule

// ===== hdl/bnms_ctrl.sv =====
// ---------------------------------------------------------------------------
// bnms_ctrl: frame controller
// Sequences intake, sorted insertion, greedy suppression and result hand-off.
// ---------------------------------------------------------------------------
module bnms_ctrl #(
	parameter int MAX_BOXES = bnms_pkg::MaxBoxesDef,
	parameter int IDX_W     = $clog2(MAX_BOXES),
	parameter int CNT_W     = $clog2(MAX_BOXES + 1)
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic                 pass,       // box passes score test
	input  logic                 in_final,
	output logic                 out_valid,
	input  logic                 out_stall,
	output bnms_pkg::bnms_cmd_t  cmd,
	input  bnms_pkg::bnms_sts_t  sts,
	output logic [IDX_W-1:0]     pivot_idx,
	output logic [IDX_W-1:0]     cand_idx,
	output logic [CNT_W-1:0]     count,
	output logic                 last_out,
	output logic                 overflow
);
	localparam logic [3:0] S_IDLE = 4'd0, S_INS = 4'd1, S_PIV = 4'd2,
		S_PIVW = 4'd3, S_CRD = 4'd4, S_CRDW = 4'd5, S_CMP = 4'd6,
		S_DRAIN = 4'd7, S_EMIT = 4'd8, S_WAIT = 4'd9, S_NEXT = 4'd10;

	logic [3:0]       state_q;
	logic [CNT_W-1:0] count_q, piv_q, cand_q;
	logic             ovf_q, final_q, out_valid_q;
	logic [1:0]       drain_q;
	logic             accept;
	logic             frame_end;

	assign accept    = in_valid && !in_stall;
	assign in_stall  = (state_q != S_IDLE) || out_valid_q;
	assign out_valid = out_valid_q;
	assign count     = count_q;
	assign overflow  = ovf_q;
	assign pivot_idx = piv_q[IDX_W-1:0];
	assign cand_idx  = cand_q[IDX_W-1:0];
	assign frame_end = (state_q == S_NEXT) && (piv_q + 1'b1 >= count_q);

	// no live box after this pivot: its result ends the list
	assign last_out  = sts.none_after;

	always_comb begin
		cmd = '0;
		cmd.ins_start  = accept && pass && (count_q != CNT_W'(MAX_BOXES));
		cmd.emit_empty = (state_q == S_IDLE) && accept && in_final && !cmd.ins_start
		                 && (count_q == '0);
		cmd.ins_step   = (state_q == S_INS);
		cmd.out_load   = (state_q == S_PIV);
		cmd.cmp_load   = (state_q == S_CRD);
		cmd.cmp_mark   = (state_q == S_CMP);
		cmd.emit       = (state_q == S_EMIT);
		cmd.res_load   = (state_q == S_WAIT) && (!out_valid_q || !out_stall);
		cmd.clear      = cmd.emit_empty || frame_end;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE; count_q <= '0; ovf_q <= 1'b0; final_q <= 1'b0;
			piv_q <= '0; cand_q <= '0; drain_q <= '0; out_valid_q <= 1'b0;
		end else begin
			// S_WAIT handles the output flag itself
			if (out_valid_q && !out_stall && (state_q != S_WAIT))
				out_valid_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (pass && count_q == CNT_W'(MAX_BOXES))
							ovf_q <= 1'b1;
						final_q <= in_final;
						if (cmd.ins_start)
							state_q <= S_INS;
						else if (in_final) begin
							if (count_q == '0) begin
								out_valid_q <= 1'b1;
								ovf_q <= 1'b0;
							end else begin
								piv_q <= '0;
								state_q <= S_PIV;
							end
						end
					end
				end
				S_INS: begin
					if (sts.ins_done) begin
						count_q <= count_q + 1'b1;
						if (final_q) begin
							piv_q <= '0;
							state_q <= S_PIV;
						end else
							state_q <= S_IDLE;
					end
				end
				S_PIV: state_q <= sts.pivot_removed ? S_NEXT : S_PIVW;
				S_PIVW: state_q <= S_EMIT;
				S_EMIT: begin
					cand_q <= piv_q + 1'b1;
					state_q <= S_CRD;
				end
				S_CRD: begin
					if (cand_q >= count_q) begin
						drain_q <= 2'd2;
						state_q <= S_DRAIN;
					end else if (sts.cand_removed)
						cand_q <= cand_q + 1'b1;
					else
						state_q <= S_CRDW;
				end
				S_CRDW: state_q <= S_CMP;
				S_CMP: begin
					cand_q <= cand_q + 1'b1;
					state_q <= S_CRD;
				end
				S_DRAIN: begin
					// let the last mark settle
					drain_q <= drain_q - 1'b1;
					if (drain_q == 2'd0)
						state_q <= S_WAIT;
				end
				S_WAIT: begin
					if (!out_valid_q || !out_stall) begin
						out_valid_q <= 1'b1;
						state_q <= S_NEXT;
					end
				end
				S_NEXT: begin
					if (frame_end) begin
						count_q <= '0; ovf_q <= 1'b0;
						state_q <= S_IDLE;
					end else begin
						piv_q <= piv_q + 1'b1;
						state_q <= S_PIV;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule

// ===== hdl/box_non_max_suppression_core.sv =====
// An item without final_box is taken in and then walks a sorted insertion through the
// box memory, which has a single write port. A final item adds the greedy sweep over
// the stored boxes, one pivot at a time, skipping removed pivots. One item at a time.
// Results wait in an output register and intake stalls meanwhile. Reset clears the box
// count, overflow flag, removal marks, thresholds to defaults; box memory is undefined.
// ---------------------------------------------------------------------------
// box_non_max_suppression_core: greedy non-maximum suppression top level
// Score filter, sorted box store, class-agnostic suppression, APB registers.
// ---------------------------------------------------------------------------
module box_non_max_suppression_core #(
	parameter int MAX_BOXES = bnms_pkg::MaxBoxesDef
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [15:0] left,
	input  logic [15:0] top,
	input  logic [15:0] right,
	input  logic [15:0] bottom,
	input  logic [15:0] confidence,
	input  logic [7:0]  class_id,
	input  logic        final_box,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [15:0] out_left,
	output logic [15:0] out_top,
	output logic [15:0] out_right,
	output logic [15:0] out_bottom,
	output logic [15:0] out_confidence,
	output logic [7:0]  out_class,
	output logic        none_kept,
	output logic        dropped_some,
	output logic        end_of_list
);
	localparam int IDX_W = (MAX_BOXES > 1) ? $clog2(MAX_BOXES) : 1;
	localparam int CNT_W = $clog2(MAX_BOXES + 1);

	logic [15:0] score_thr_q, overlap_thr_q;
	bnms_pkg::bnms_cmd_t cmd;
	bnms_pkg::bnms_sts_t sts;
	logic [IDX_W-1:0] pivot_idx, cand_idx;
	logic [CNT_W-1:0] count;
	logic last_out, overflow, res_last;
	logic [bnms_pkg::BoxW-1:0] res_box;

	// register file
	assign pready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			score_thr_q   <= bnms_pkg::ScoreThrReset;
			overlap_thr_q <= bnms_pkg::OverlapThrReset;
		end else if (psel && penable && pwrite && paddr[1:0] == 2'b00 && !paddr[2]) begin
			score_thr_q <= pwdata[15:0];
		end else if (psel && penable && pwrite && paddr[1:0] == 2'b00 && paddr[2]) begin
			overlap_thr_q <= pwdata[15:0];
		end
	end
	always_comb begin
		case (paddr[2])
			bnms_pkg::RegScoreThr:   prdata = {16'd0, score_thr_q};
			bnms_pkg::RegOverlapThr: prdata = {16'd0, overlap_thr_q};
			default:                 prdata = '0;
		endcase
	end

	bnms_ctrl #(.MAX_BOXES(MAX_BOXES), .IDX_W(IDX_W), .CNT_W(CNT_W)) u_ctrl (
		.clk, .arst_n, .in_valid, .in_stall,
		.pass(confidence >= score_thr_q), .in_final(final_box),
		.out_valid, .out_stall, .cmd, .sts, .pivot_idx, .cand_idx, .count,
		.last_out, .overflow
	);

	bnms_datapath #(.MAX_BOXES(MAX_BOXES), .IDX_W(IDX_W), .CNT_W(CNT_W)) u_dp (
		.clk, .arst_n, .cmd, .sts, .pivot_idx, .cand_idx, .count,
		.overlap_thr(overlap_thr_q),
		.new_box({class_id, confidence, bottom, right, top, left}),
		.last_out, .overflow, .res_box, .res_none(none_kept), .res_drop(dropped_some),
		.res_last
	);

	assign out_left       = res_box[15:0];
	assign out_top        = res_box[31:16];
	assign out_right      = res_box[47:32];
	assign out_bottom     = res_box[63:48];
	assign out_confidence = res_box[79:64];
	assign out_class      = res_box[87:80];
	assign end_of_list    = res_last;
endmodule

// ===== hdl/bnms_checker.sv =====
// ---------------------------------------------------------------------------
// bnms_checker: port-level checks for the suppression core
// Watches handshakes and result framing over time.
// ---------------------------------------------------------------------------
module bnms_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_stall,
	input logic        out_valid,
	input logic        out_stall,
	input logic [15:0] out_left,
	input logic        none_kept,
	input logic        end_of_list,
	input logic        pready
);
	// a held result stays valid and keeps its left coordinate
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_left))
		else $error("result changed while stalled");

	// an empty-frame result is always the end of the list
	a_empty_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && none_kept |-> end_of_list)
		else $error("empty result not last");

	// no intake while a result waits
	a_no_intake: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> in_stall)
		else $error("input taken with result pending");

	a_ready: assert property (@(posedge clk) disable iff (!arst_n) pready)
		else $error("pready low");
endmodule

bind box_non_max_suppression_core bnms_checker u_chk (
	.clk, .arst_n, .in_valid, .in_stall, .out_valid, .out_stall, .out_left,
	.none_kept, .end_of_list, .pready
);
